### rtl/byte_record_to_json_text_macros.svh
// assertion macros used by the top level of the json text renderer
`ifndef BYTE_RECORD_TO_JSON_TEXT_MACROS_SVH
`define BYTE_RECORD_TO_JSON_TEXT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BRJT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define BRJT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BRJT_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define BRJT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/brjt_pkg.sv
// shared types, character codes and key table of the json text renderer
`default_nettype none
package brjt_pkg;

   localparam int BRJT_MAX_KEYS = 10;
   localparam int NAMED_KEYS    = 6;

   // ascii characters
   localparam logic [7:0] CHAR_OPEN  = 8'h7B;
   localparam logic [7:0] CHAR_CLOSE = 8'h7D;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   // character select codes from controller to datapath
   localparam logic [2:0] SEL_OPEN  = 3'd0;
   localparam logic [2:0] SEL_QUOTE = 3'd1;
   localparam logic [2:0] SEL_KEY   = 3'd2;
   localparam logic [2:0] SEL_COLON = 3'd3;
   localparam logic [2:0] SEL_HUND  = 3'd4;
   localparam logic [2:0] SEL_TENS  = 3'd5;
   localparam logic [2:0] SEL_ONES  = 3'd6;
   localparam logic [2:0] SEL_END   = 3'd7;

   typedef struct packed {
      logic       load;
      logic       emit;
      logic [2:0] sel;
   } brjt_cmd_type;

   typedef struct packed {
      logic at_start;
      logic slot_free;
      logic key_empty;
      logic key_last;
      logic ge_100;
      logic ge_10;
   } brjt_stat_type;

   // key name length, zero for keys past the named ones
   function automatic logic [3:0] key_len(input logic [3:0] k);
      logic [3:0] len;
      case (k)
         4'd0:    len = 4'd9;
         4'd1:    len = 4'd6;
         4'd2:    len = 4'd4;
         4'd3:    len = 4'd4;
         4'd4:    len = 4'd4;
         4'd5:    len = 4'd7;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   // one character of a key name, left aligned rows of nine characters
   function automatic logic [7:0] key_char(input logic [3:0] k, input logic [3:0] pos);
      logic [71:0] row;
      logic [71:0] shifted;
      case (k)
         4'd0:    row = "GateWayID";
         4'd1:    row = {"NodeID", 24'h0};
         4'd2:    row = {"Flag", 40'h0};
         4'd3:    row = {"Temp", 40'h0};
         4'd4:    row = {"Humi", 40'h0};
         4'd5:    row = {"Battery", 16'h0};
         default: row = '0;
      endcase
      shifted = row << {pos, 3'b000};
      return shifted[71:64];
   endfunction

endpackage
`default_nettype wire

### rtl/brjt_ctrl.sv
// sequencer that walks through the characters of one field
`default_nettype none
module brjt_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire brjt_pkg::brjt_stat_type stat,
   output brjt_pkg::brjt_cmd_type      cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_OPEN   = 4'd1;
   localparam logic [3:0] ST_QUOTE1 = 4'd2;
   localparam logic [3:0] ST_KEY    = 4'd3;
   localparam logic [3:0] ST_QUOTE2 = 4'd4;
   localparam logic [3:0] ST_COLON  = 4'd5;
   localparam logic [3:0] ST_HUND   = 4'd6;
   localparam logic [3:0] ST_TENS   = 4'd7;
   localparam logic [3:0] ST_ONES   = 4'd8;
   localparam logic [3:0] ST_END    = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       busy;

   assign busy      = (state_ff != ST_IDLE);
   assign req_ready = !busy;

   // commands
   always_comb begin
      cmd.load = req_valid && !busy;
      cmd.emit = busy && stat.slot_free;
      unique case (state_ff)
         ST_OPEN:   cmd.sel = brjt_pkg::SEL_OPEN;
         ST_KEY:    cmd.sel = brjt_pkg::SEL_KEY;
         ST_COLON:  cmd.sel = brjt_pkg::SEL_COLON;
         ST_HUND:   cmd.sel = brjt_pkg::SEL_HUND;
         ST_TENS:   cmd.sel = brjt_pkg::SEL_TENS;
         ST_ONES:   cmd.sel = brjt_pkg::SEL_ONES;
         ST_END:    cmd.sel = brjt_pkg::SEL_END;
         default:   cmd.sel = brjt_pkg::SEL_QUOTE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = stat.at_start ? ST_OPEN : ST_QUOTE1;
         end
         ST_OPEN: begin
            if (stat.slot_free) state_in = ST_QUOTE1;
         end
         ST_QUOTE1: begin
            if (stat.slot_free) state_in = stat.key_empty ? ST_QUOTE2 : ST_KEY;
         end
         ST_KEY: begin
            if (stat.slot_free && stat.key_last) state_in = ST_QUOTE2;
         end
         ST_QUOTE2: begin
            if (stat.slot_free) state_in = ST_COLON;
         end
         ST_COLON: begin
            if (stat.slot_free) begin
               if (stat.ge_100)     state_in = ST_HUND;
               else if (stat.ge_10) state_in = ST_TENS;
               else                 state_in = ST_ONES;
            end
         end
         ST_HUND: begin
            if (stat.slot_free) state_in = ST_TENS;
         end
         ST_TENS: begin
            if (stat.slot_free) state_in = ST_ONES;
         end
         ST_ONES: begin
            if (stat.slot_free) state_in = ST_END;
         end
         ST_END: begin
            if (stat.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### rtl/brjt_dp.sv
// record state, digit split, character mux and output register
`default_nettype none
module brjt_dp #(
   parameter int MAX_KEYS = brjt_pkg::BRJT_MAX_KEYS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire brjt_pkg::brjt_cmd_type cmd,
   input  wire logic [7:0]            req_value,
   input  wire logic                  req_last,
   input  wire logic                  rsp_ready,
   output brjt_pkg::brjt_stat_type    stat,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_end_of_text,
   output logic [7:0]                 rsp_text_length,
   output logic                       rsp_format_error
);

   // record state
   logic       at_start_ff, at_start_in;
   logic [3:0] field_ff, field_in;
   logic [7:0] chars_ff, chars_in;
   logic       error_ff, error_in;
   // current field
   logic [7:0] value_ff;
   logic       last_ff;
   logic [3:0] key_ff, key_pos_ff;
   // digit pipeline
   logic [1:0] hund_ff;
   logic [6:0] rem_ff;
   logic [3:0] tens_ff;
   // output register
   logic       valid_ff;
   logic [7:0] char_ff;
   logic       eot_ff, err_out_ff;
   logic [7:0] len_ff;

   logic [3:0]  key_k, field_base, klen;
   logic [14:0] tens_prod;
   logic [6:0]  tens_x10, ones_full;
   logic [7:0]  chars_next, char_sel;

   assign field_base = at_start_ff ? 4'd0 : field_ff;
   assign key_k      = field_base;
   assign klen       = brjt_pkg::key_len(key_ff);

   // status
   assign stat.at_start  = at_start_ff;
   assign stat.slot_free = !valid_ff || rsp_ready;
   assign stat.key_empty = (klen == 4'd0);
   assign stat.key_last  = (key_pos_ff == klen - 4'd1);
   assign stat.ge_100    = (value_ff >= 8'd100);
   assign stat.ge_10     = (value_ff >= 8'd10);

   // record state updated when a transaction is taken, character count on each emit
   always_comb begin
      at_start_in = at_start_ff;
      field_in    = field_ff;
      chars_in    = chars_ff;
      error_in    = error_ff;
      if (cmd.load) begin
         at_start_in = req_last;
         field_in    = (field_base < 4'(MAX_KEYS)) ? field_base + 4'd1 : field_base;
         chars_in    = at_start_ff ? 8'd0 : chars_ff;
         error_in    = (at_start_ff ? 1'b0 : error_ff) |
                       (key_k >= 4'(brjt_pkg::NAMED_KEYS));
      end else if (cmd.emit) begin
         chars_in = chars_next;
      end
   end

   assign chars_next = (chars_ff == 8'd255) ? chars_ff : chars_ff + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         field_ff    <= '0;
         chars_ff    <= '0;
         error_ff    <= 1'b0;
      end else begin
         at_start_ff <= at_start_in;
         field_ff    <= field_in;
         chars_ff    <= chars_in;
         error_ff    <= error_in;
      end
   end

   // field payload and key position
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff   <= req_value;
         last_ff    <= req_last;
         key_ff     <= key_k;
         key_pos_ff <= '0;
      end else if (cmd.emit && cmd.sel == brjt_pkg::SEL_KEY) begin
         key_pos_ff <= key_pos_ff + 4'd1;
      end
   end

   // decimal split: hundreds by compare, tens by reciprocal multiply
   assign tens_prod = 15'(rem_ff) * 15'd205;
   assign tens_x10  = {tens_ff, 3'b000} + {2'b00, tens_ff, 1'b0};
   assign ones_full = rem_ff - tens_x10;

   always_ff @(posedge clock) begin
      if (value_ff >= 8'd200) begin
         hund_ff <= 2'd2;
         rem_ff  <= 7'(value_ff - 8'd200);
      end else if (value_ff >= 8'd100) begin
         hund_ff <= 2'd1;
         rem_ff  <= 7'(value_ff - 8'd100);
      end else begin
         hund_ff <= 2'd0;
         rem_ff  <= value_ff[6:0];
      end
      tens_ff <= tens_prod[14:11];
   end

   // character select
   always_comb begin
      unique case (cmd.sel)
         brjt_pkg::SEL_OPEN:  char_sel = brjt_pkg::CHAR_OPEN;
         brjt_pkg::SEL_QUOTE: char_sel = brjt_pkg::CHAR_QUOTE;
         brjt_pkg::SEL_KEY:   char_sel = brjt_pkg::key_char(key_ff, key_pos_ff);
         brjt_pkg::SEL_COLON: char_sel = brjt_pkg::CHAR_COLON;
         brjt_pkg::SEL_HUND:  char_sel = brjt_pkg::CHAR_ZERO + {6'd0, hund_ff};
         brjt_pkg::SEL_TENS:  char_sel = brjt_pkg::CHAR_ZERO + {4'd0, tens_ff};
         brjt_pkg::SEL_ONES:  char_sel = brjt_pkg::CHAR_ZERO + {4'd0, ones_full[3:0]};
         brjt_pkg::SEL_END:   char_sel = last_ff ? brjt_pkg::CHAR_CLOSE
                                                 : brjt_pkg::CHAR_COMMA;
         default:             char_sel = brjt_pkg::CHAR_QUOTE;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         char_ff    <= char_sel;
         eot_ff     <= (cmd.sel == brjt_pkg::SEL_END) && last_ff;
         len_ff     <= chars_next;
         err_out_ff <= error_ff;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_char     = char_ff;
   assign rsp_end_of_text  = eot_ff;
   assign rsp_text_length  = len_ff;
   assign rsp_format_error = err_out_ff;

endmodule
`default_nettype wire

### rtl/byte_record_to_json_text.sv
// top level of the byte record to json text renderer
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  value[7:0], last
//   rsp_     out        rsp_valid/rsp_ready  out_char[7:0], end_of_text,
//                                            text_length[7:0], format_error
//
// each byte is taken and then written out one character at a time; the
// character count is set by the key length and the digit count of the byte.
// a new byte is taken while the last character of the previous one waits.
// synchronous active-high reset, no clearing pass.
// rsp_ready low holds the sequencer on the pending character.
`default_nettype none
`include "byte_record_to_json_text_macros.svh"
module byte_record_to_json_text #(
   parameter int MAX_KEYS = brjt_pkg::BRJT_MAX_KEYS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_value,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_end_of_text,
   output logic [7:0]      rsp_text_length,
   output logic            rsp_format_error
);

   brjt_pkg::brjt_cmd_type  cmd;
   brjt_pkg::brjt_stat_type stat;
   logic                    rsp_close;

   brjt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   brjt_dp #(
      .MAX_KEYS (MAX_KEYS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_ready        (rsp_ready),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_out_char     (rsp_out_char),
      .rsp_end_of_text  (rsp_end_of_text),
      .rsp_text_length  (rsp_text_length),
      .rsp_format_error (rsp_format_error)
   );

   assign rsp_close = (rsp_out_char == brjt_pkg::CHAR_CLOSE);

   // checks
   `BRJT_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)
   `BRJT_ASSERT_NOW(a_eot_is_brace, clock, reset, rsp_valid && rsp_end_of_text, rsp_close)
   `BRJT_ASSERT_NOW(a_length_nonzero, clock, reset, rsp_valid, rsp_text_length != 8'd0)
   `BRJT_ASSERT_NOW(a_no_load_while_emit, clock, reset, cmd.load, !cmd.emit)

endmodule
`default_nettype wire
